[rtl/core/tga_rle_pixel_decoder_assert.svh]
// Assertion macros for the TGA run-length pixel decoder.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define TRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define TRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TRD_ASSERT(lbl, prop, msg)
`define TRD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/trd_pkg.sv]
// Shared types and constants of the TGA run-length pixel decoder.
// No dependencies; imported by every module of the block.
package trd_pkg;

  // Largest pixel, in bytes.
  localparam int unsigned PIX_BYTES  = 4;
  localparam int unsigned PIX_W      = 8 * PIX_BYTES;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned TOTAL_W    = 31;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Header bytes below this value open a raw packet.
  localparam logic [7:0] RUN_FLAG   = 8'd128;
  localparam logic [7:0] RUN_OFFSET = 8'd127;

  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 31'd1;

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_BPP   = 1'b0,
    REG_TOTAL = 1'b1
  } reg_idx_e;

  // Packet parser phase.
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_RAW    = 3'b010,
    PH_RUN    = 3'b100
  } phase_e;

  typedef struct packed {
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic [TOTAL_W-1:0] pixel_total;
  } cfg_t;

  // One decoded result word.
  typedef struct packed {
    logic [PIX_W-1:0]   pixel_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               image_done;
    logic               overflow;
  } pix_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/trd_byte_if.sv]
// Byte stream channel of the TGA run-length pixel decoder.
// Depends on nothing.
interface trd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

[rtl/core/trd_pix_if.sv]
// Pixel result channel of the TGA run-length pixel decoder.
// Depends on nothing.
interface trd_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        image_done;
  logic        overflow;

  modport source (output valid, output pixel_value, output repeat_count,
                  output image_done, output overflow, input ready);
  modport sink   (input valid, input pixel_value, input repeat_count,
                  input image_done, input overflow, output ready);
endinterface

[rtl/core/tga_rle_pixel_decoder.sv]
// Top level of the TGA run-length pixel decoder: configuration registers,
// front end, result queue and output stage. Depends on trd_pkg, the channel
// interfaces and tga_rle_pixel_decoder_assert.svh.
//
//   Channel   Direction  Word                    Handshake
//   in_chan   in         data_byte (8)           valid / ready
//   out_chan  out        pixel, count, flags     valid / ready
//   APB       in         bytes_per_pixel, total  psel / penable / pready
//
// One byte is accepted per cycle while the queue has room; a result is pushed
// with the byte that ends its pixel, then passes queue and output register.
// Throughput is bound by the front end's pixel accounting loop.
// Reset is asynchronous and clears parser state, queue and output valid.
// A stalled output fills the two-entry queue; input ready drops when it is full.
`include "tga_rle_pixel_decoder_assert.svh"
module tga_rle_pixel_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  trd_byte_if.sink                  in_chan,
  trd_pix_if.source                 out_chan,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [trd_pkg::PADDR_W-1:0] paddr,
  input  logic [trd_pkg::PDATA_W-1:0] pwdata,
  output logic [trd_pkg::PDATA_W-1:0] prdata,
  output logic                      pready
);
  import trd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_we;
  logic     accept;
  logic     push, pop;
  pix_res_t push_res, head_res;
  q_stat_t  q_stat;

  // Configuration port: always ready, registers at word addresses.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_pixel <= BPP_RESET;
      cfg_q.pixel_total     <= TOTAL_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_BPP:   cfg_q.bytes_per_pixel <= pwdata[BPP_W-1:0];
        REG_TOTAL: cfg_q.pixel_total     <= pwdata[TOTAL_W-1:0];
        default:   ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_BPP:   prdata = PDATA_W'(cfg_q.bytes_per_pixel);
      REG_TOTAL: prdata = PDATA_W'(cfg_q.pixel_total);
      default:   prdata = '0;
    endcase
  end

  // Input is taken whenever the queue has room for a result.
  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  trd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (in_chan.data_byte),
    .push_o      (push),
    .res_o       (push_res)
  );

  trd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_res),
    .pop_i       (pop),
    .pop_data_o  (head_res),
    .stat_o      (q_stat)
  );

  trd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_res),
    .stat_i   (q_stat),
    .pop_o    (pop),
    .out_chan (out_chan)
  );

  // Overflow is only ever reported on the word that ends the image.
  `TRD_ASSERT(a_ovf_done, out_chan.valid && out_chan.overflow |-> out_chan.image_done, "overflow without image_done")
  // A waiting queue word reaches an empty output register in the next cycle.
  `TRD_ASSERT(a_drain, !out_chan.valid && !q_stat.empty |=> out_chan.valid, "queue word not forwarded")
  // A pushed word is never lost: a push into a full queue cannot happen.
  `TRD_ASSERT(a_no_push_full, push |-> !q_stat.full, "result pushed into full queue")
  // The queue can never be both full and empty.
  `TRD_ASSERT_ALWAYS(a_q_stat, !(q_stat.full && q_stat.empty), "queue status inconsistent")

endmodule

[rtl/core/trd_front.sv]
// Front end: packet header parsing, pixel byte gathering and pixel accounting.
// Depends on trd_pkg; pushes finished result words into the queue.
module trd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trd_pkg::cfg_t     cfg_i,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  output logic              push_o,
  output trd_pkg::pix_res_t res_o
);
  import trd_pkg::*;

  phase_e               phase_q, phase_d;
  logic [COUNT_W-1:0]   left_q, left_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [PIX_W-1:0]     gather_q, gather_d;
  logic [TOTAL_W-1:0]   emitted_q, emitted_d;

  logic [BPP_W-1:0]     eff_bpp;
  logic [BPP_W-1:0]     pos_inc;
  logic                 last_byte;
  logic [PIX_W-1:0]     full_pix;
  logic [COUNT_W-1:0]   cnt_base;
  logic [COUNT_W-1:0]   count;
  logic [TOTAL_W:0]     remaining;
  logic                 no_room;
  logic                 done;
  logic                 ovf;
  logic                 raw_more;

  // Bytes per pixel clamped to the supported range.
  always_comb begin
    if (cfg_i.bytes_per_pixel == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (cfg_i.bytes_per_pixel > BPP_W'(PIX_BYTES)) begin
      eff_bpp = BPP_W'(PIX_BYTES);
    end else begin
      eff_bpp = cfg_i.bytes_per_pixel;
    end
  end

  // Pixel assembly and the count, done and overflow decision.
  always_comb begin
    pos_inc   = {1'b0, pos_q} + BPP_W'(1);
    last_byte = !(pos_inc < eff_bpp);
    full_pix  = gather_q | (PIX_W'(data_byte_i) << {pos_q, 3'b000});
    raw_more  = (phase_q == PH_RAW) && (left_q > COUNT_W'(1));

    cnt_base = (phase_q == PH_RUN) ? left_q : COUNT_W'(1);
    if (cnt_base == '0) begin
      cnt_base = COUNT_W'(1);
    end

    remaining = {1'b0, cfg_i.pixel_total} - {1'b0, emitted_q};
    no_room   = remaining[TOTAL_W] || (remaining == '0);
    count     = cnt_base;
    done      = 1'b0;
    ovf       = 1'b0;
    if (no_room) begin
      count = COUNT_W'(1);
      done  = 1'b1;
      ovf   = 1'b1;
    end else if ((TOTAL_W+1)'(cnt_base) > remaining) begin
      count = remaining[COUNT_W-1:0];
      done  = 1'b1;
      ovf   = 1'b1;
    end else if ((TOTAL_W+1)'(cnt_base) == remaining) begin
      done  = 1'b1;
      ovf   = raw_more;
    end
  end

  // Next state of the parser.
  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    pos_d     = pos_q;
    gather_d  = gather_q;
    emitted_d = emitted_q;
    push_o    = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PH_RAW, PH_RUN: begin
          if (!last_byte) begin
            gather_d = full_pix;
            pos_d    = pos_inc[POS_W-1:0];
          end else begin
            push_o   = 1'b1;
            pos_d    = '0;
            gather_d = '0;
            if (done) begin
              phase_d   = PH_HEADER;
              left_d    = '0;
              emitted_d = '0;
            end else begin
              // Without done the count is never clipped, so the base count
              // is added and the sum runs beside the remaining-pixel compare.
              emitted_d = emitted_q + TOTAL_W'(cnt_base);
              if (raw_more) begin
                left_d = left_q - COUNT_W'(1);
              end else begin
                phase_d = PH_HEADER;
                left_d  = '0;
              end
            end
          end
        end
        default: begin
          if (data_byte_i < RUN_FLAG) begin
            phase_d = PH_RAW;
            left_d  = data_byte_i + COUNT_W'(1);
          end else begin
            phase_d = PH_RUN;
            left_d  = data_byte_i - RUN_OFFSET;
          end
          pos_d    = '0;
          gather_d = '0;
        end
      endcase
    end
  end

  assign res_o = '{pixel_value:  full_pix,
                   repeat_count: count,
                   image_done:   done,
                   overflow:     ovf};

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      left_q    <= '0;
      pos_q     <= '0;
      gather_q  <= '0;
      emitted_q <= '0;
    end else begin
      phase_q   <= phase_d;
      left_q    <= left_d;
      pos_q     <= pos_d;
      gather_q  <= gather_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

[rtl/core/trd_queue.sv]
// Short result queue between the front end and the output stage.
// Depends on trd_pkg; holds QUEUE_DEPTH result words.
module trd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  trd_pkg::pix_res_t push_data_i,
  input  logic              pop_i,
  output trd_pkg::pix_res_t pop_data_o,
  output trd_pkg::q_stat_t  stat_o
);
  import trd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_res_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/trd_back.sv]
// Output stage: drains the queue into a registered result channel.
// Depends on trd_pkg and trd_pix_if.
module trd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trd_pkg::pix_res_t head_i,
  input  trd_pkg::q_stat_t  stat_i,
  output logic              pop_o,
  trd_pix_if.source         out_chan
);
  import trd_pkg::*;

  logic     valid_q, valid_d;
  pix_res_t data_q;

  // Load a new word whenever the register is empty or being taken.
  assign pop_o   = (!valid_q || out_chan.ready) && !stat_i.empty;
  assign valid_d = pop_o ? 1'b1 : (valid_q && !out_chan.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  assign out_chan.valid        = valid_q;
  assign out_chan.pixel_value  = data_q.pixel_value;
  assign out_chan.repeat_count = data_q.repeat_count;
  assign out_chan.image_done   = data_q.image_done;
  assign out_chan.overflow     = data_q.overflow;

endmodule
